// File: rtl/core/dual_resource_grant_arbiter_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the dual resource grant arbiter
// Clocked concurrent checks with asynchronous active-low reset gating.
// ----------------------------------------------------------------------------
`ifndef DUAL_RESOURCE_GRANT_ARBITER_ASSERT_SVH
`define DUAL_RESOURCE_GRANT_ARBITER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// property must hold at every clock edge out of reset
`define DRGA_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: assertion failed");
// expression must never be true out of reset
`define DRGA_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("%m: forbidden condition seen");
`else
`define DRGA_ASSERT(lbl, clk, rst_n, prop)
`define DRGA_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// File: rtl/core/drga_pkg.sv
// ----------------------------------------------------------------------------
// drga_pkg
// Shared types and constants of the dual resource grant arbiter.
// ----------------------------------------------------------------------------
package drga_pkg;

	localparam int SEAT_W         = 5;
	localparam int CFG_W          = 5;
	localparam int MAX_SEATS_DEF  = 16;
	localparam int QUEUE_DEPTH    = 2;
	localparam int APB_DATA_W     = 32;
	localparam int APB_ADDR_W     = 3;

	localparam logic [CFG_W-1:0] NUM_SEATS_RESET = CFG_W'(5);

	// command codes
	localparam logic CMD_REQUEST = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	// register word index
	localparam logic REG_NUM_SEATS = 1'b0;

	typedef enum logic [1:0] {
		EV_GRANT   = 2'd0,
		EV_QUEUED  = 2'd1,
		EV_RELEASE = 2'd2,
		EV_REJECT  = 2'd3
	} event_t;

	typedef enum logic [1:0] {
		KIND_REQ,
		KIND_REL,
		KIND_REJ
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [SEAT_W-1:0] seat;
	} cmd_item_t;

	typedef struct packed {
		event_t            ev;
		logic [SEAT_W-1:0] seat;
		logic              last;
	} result_t;

endpackage

// File: rtl/core/drga_front.sv
// ----------------------------------------------------------------------------
// drga_front
// Request intake: range check of the seat and command classification.
// ----------------------------------------------------------------------------
module drga_front (
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic                          cmd,
	input  logic [drga_pkg::SEAT_W-1:0]   seat,
	input  logic [drga_pkg::SEAT_W-1:0]   eff_seats,
	input  logic                          q_full,
	output logic                          q_push,
	output drga_pkg::cmd_item_t           q_item
);
	import drga_pkg::*;

	logic seat_bad;

	assign seat_bad = (seat == '0) || (seat > eff_seats);
	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

	always_comb begin
		q_item.seat = seat;
		if (seat_bad) begin
			q_item.kind = KIND_REJ;
		end else if (cmd == CMD_RELEASE) begin
			q_item.kind = KIND_REL;
		end else begin
			q_item.kind = KIND_REQ;
		end
	end

endmodule

// File: rtl/core/drga_queue.sv
// ----------------------------------------------------------------------------
// drga_queue
// Short FIFO of classified requests between intake and execution.
// ----------------------------------------------------------------------------
module drga_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  drga_pkg::cmd_item_t  push_item,
	output logic                 full,
	input  logic                 pop,
	output logic                 not_empty,
	output drga_pkg::cmd_item_t  pop_item
);
	import drga_pkg::*;

	localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CntW = $clog2(QUEUE_DEPTH + 1);

	cmd_item_t         slots_q [QUEUE_DEPTH];
	logic [PtrW-1:0]   wr_ptr_q;
	logic [PtrW-1:0]   rd_ptr_q;
	logic [CntW-1:0]   count_q;

	assign full      = (count_q == CntW'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_item  = slots_q[rd_ptr_q];

	function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
		logic [PtrW-1:0] r;
		if (p == PtrW'(QUEUE_DEPTH - 1)) r = '0;
		else r = p + PtrW'(1);
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop)  rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (push && !pop) count_q <= count_q + CntW'(1);
			else if (pop && !push) count_q <= count_q - CntW'(1);
		end
	end

endmodule

// File: rtl/core/drga_back.sv
// ----------------------------------------------------------------------------
// drga_back
// Execution: lock map, wait queue memory, release scan, result register.
// ----------------------------------------------------------------------------
module drga_back #(
	parameter int MAX_SEATS = drga_pkg::MAX_SEATS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              clear,
	input  logic [drga_pkg::SEAT_W-1:0]       eff_seats,
	input  logic                              q_valid,
	input  drga_pkg::cmd_item_t               q_item,
	output logic                              q_pop,
	output logic                              out_valid,
	input  logic                              out_ready,
	output drga_pkg::result_t                 out_res,
	output logic [MAX_SEATS-1:0]              lock_free,
	output logic [$clog2(MAX_SEATS+1)-1:0]    wait_count
);
	import drga_pkg::*;

	localparam int AddrW = $clog2(MAX_SEATS);
	localparam int CntW  = $clog2(MAX_SEATS + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	state_t              state_q;
	logic [MAX_SEATS-1:0] lock_q;
	logic [CntW-1:0]     count_q;
	logic [CntW-1:0]     rd_q;
	logic [CntW-1:0]     wr_q;
	logic [1:0]          grants_q;
	event_t              pend_ev_q;
	logic [SEAT_W-1:0]   pend_seat_q;
	logic                out_valid_q;
	result_t             out_q;

	logic [SEAT_W-1:0]   mem [MAX_SEATS];
	logic [SEAT_W-1:0]   mem_rd_q;

	logic                 out_free;
	logic                 out_load;
	logic [MAX_SEATS-1:0] req_mask;
	logic                 req_ok;
	logic [MAX_SEATS-1:0] w_mask;
	logic                 w_ok;
	logic                 scan_step;
	logic                 scan_last;
	logic                 q_full_wait;
	logic                 ren;
	logic [AddrW-1:0]     raddr;
	logic                 we;
	logic [AddrW-1:0]     waddr;
	logic [SEAT_W-1:0]    wdata;

	// both locks of seat s: s-1 and s, the latter wrapping to 0 at the ring end
	function automatic logic [MAX_SEATS-1:0] seat_mask(
		input logic [SEAT_W-1:0] s,
		input logic [SEAT_W-1:0] n
	);
		logic [SEAT_W-1:0]    left;
		logic [SEAT_W-1:0]    right;
		logic [MAX_SEATS-1:0] m;
		left  = s - SEAT_W'(1);
		right = (s == n) ? '0 : s;
		for (int i = 0; i < MAX_SEATS; i++) begin
			m[i] = (i == int'(left)) || (i == int'(right));
		end
		return m;
	endfunction

	assign out_free    = !out_valid_q || out_ready;
	assign req_mask    = seat_mask(q_item.seat, eff_seats);
	assign req_ok      = (lock_q & req_mask) == req_mask;
	assign q_full_wait = (count_q == CntW'(MAX_SEATS));
	assign w_mask      = seat_mask(mem_rd_q, eff_seats);
	assign w_ok        = (grants_q < 2'd2) && (mem_rd_q != '0) && (mem_rd_q <= eff_seats)
	                     && ((lock_q & w_mask) == w_mask);
	assign scan_last   = (rd_q + CntW'(1)) == count_q;
	assign scan_step   = (state_q == ST_SCAN) && (!w_ok || out_free);
	assign q_pop       = (state_q == ST_IDLE) && q_valid && out_free;

	// a new result enters the output register this cycle
	assign out_load = (q_pop && (q_item.kind != KIND_REL)) || (scan_step && w_ok)
	                  || ((state_q == ST_FLUSH) && out_free);

	// prefetch: entry 0 on a release, next entry on each scan step but the last
	assign ren   = (q_pop && (q_item.kind == KIND_REL)) || (scan_step && !scan_last);
	assign raddr = (state_q == ST_IDLE) ? '0 : AddrW'(rd_q + CntW'(1));

	always_comb begin
		we    = 1'b0;
		waddr = count_q[AddrW-1:0];
		wdata = q_item.seat;
		if (q_pop && (q_item.kind == KIND_REQ) && !req_ok && !q_full_wait) begin
			we = 1'b1;
		end else if (scan_step && !w_ok) begin
			we    = 1'b1;
			waddr = wr_q[AddrW-1:0];
			wdata = mem_rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (ren) mem_rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			lock_q      <= '1;
			count_q     <= '0;
			rd_q        <= '0;
			wr_q        <= '0;
			grants_q    <= '0;
			pend_ev_q   <= EV_RELEASE;
			pend_seat_q <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else if (clear) begin
			state_q <= ST_IDLE;
			lock_q  <= '1;
			count_q <= '0;
		end else begin
			out_valid_q <= out_load || (out_valid_q && !out_ready);
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						unique case (q_item.kind)
							KIND_REQ: begin
								out_q.seat  <= q_item.seat;
								out_q.last  <= 1'b1;
								if (req_ok) begin
									lock_q   <= lock_q & ~req_mask;
									out_q.ev <= EV_GRANT;
								end else if (!q_full_wait) begin
									count_q  <= count_q + CntW'(1);
									out_q.ev <= EV_QUEUED;
								end else begin
									out_q.ev <= EV_REJECT;
								end
							end
							KIND_REL: begin
								lock_q      <= lock_q | req_mask;
								pend_ev_q   <= EV_RELEASE;
								pend_seat_q <= q_item.seat;
								rd_q        <= '0;
								wr_q        <= '0;
								grants_q    <= '0;
								state_q     <= (count_q == '0) ? ST_FLUSH : ST_SCAN;
							end
							default: begin
								out_q.ev    <= EV_REJECT;
								out_q.seat  <= q_item.seat;
								out_q.last  <= 1'b1;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (scan_step) begin
						if (w_ok) begin
							lock_q      <= lock_q & ~w_mask;
							out_q.ev    <= pend_ev_q;
							out_q.seat  <= pend_seat_q;
							out_q.last  <= 1'b0;
							pend_ev_q   <= EV_GRANT;
							pend_seat_q <= mem_rd_q;
							grants_q    <= grants_q + 2'd1;
						end else begin
							wr_q <= wr_q + CntW'(1);
						end
						if (scan_last) begin
							count_q <= w_ok ? wr_q : wr_q + CntW'(1);
							state_q <= ST_FLUSH;
						end else begin
							rd_q <= rd_q + CntW'(1);
						end
					end
				end
				ST_FLUSH: begin
					if (out_free) begin
						out_q.ev    <= pend_ev_q;
						out_q.seat  <= pend_seat_q;
						out_q.last  <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign out_res    = out_q;
	assign lock_free  = lock_q;
	assign wait_count = count_q;

endmodule

// File: rtl/core/dual_resource_grant_arbiter.sv
// ----------------------------------------------------------------------------
// dual_resource_grant_arbiter
// Central arbiter granting each seat of a ring its two neighboring locks.
// Path: request or rejected command: intake queue, then result register.
// Throughput: requests sustain 1 per cycle unless stalled; a release holds
//   the executor for a scan (one queued seat examined per cycle if unstalled).
// Results: release then up to two grants, the last flagged by m_tlast.
// Reset: arst_n async; all locks free, wait queue empty, num_seats = 5.
// ----------------------------------------------------------------------------
`include "dual_resource_grant_arbiter_assert.svh"

module dual_resource_grant_arbiter #(
	parameter int MAX_SEATS = drga_pkg::MAX_SEATS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// APB configuration port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [drga_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [drga_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [drga_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready,
	// command stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [7:0]                        s_tdata,  // [0] cmd, [5:1] seat, [7:6] zero
	// result stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [7:0]                        m_tdata,  // [1:0] event_res, [6:2] target_seat
	output logic                              m_tlast
);
	import drga_pkg::*;

	localparam int CntW = $clog2(MAX_SEATS + 1);

	logic [CFG_W-1:0]     num_seats_q;
	logic [SEAT_W-1:0]    eff_seats;
	logic                 cfg_wr;
	logic                 reg_sel;

	logic                 q_push;
	logic                 q_full;
	logic                 q_pop;
	logic                 q_valid;
	cmd_item_t            push_item;
	cmd_item_t            pop_item;

	logic                 out_valid;
	result_t              out_res;
	logic [MAX_SEATS-1:0] lock_free;
	logic [CntW-1:0]      wait_count;
	logic                 grant_out;
	logic                 grant_seat_ok;

	// ---------------- configuration ----------------
	// One register at word 0. Writing it also wipes locks and wait queue,
	// handled in the executor through cfg_wr.
	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == REG_NUM_SEATS);
	assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;
	assign prdata  = reg_sel ? APB_DATA_W'(num_seats_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_seats_q <= NUM_SEATS_RESET;
		end else if (cfg_wr) begin
			num_seats_q <= pwdata[CFG_W-1:0];
		end
	end

	// ring size in use: register clamped to 2..MAX_SEATS
	always_comb begin
		if (num_seats_q < CFG_W'(2)) begin
			eff_seats = SEAT_W'(2);
		end else if (int'(num_seats_q) > MAX_SEATS) begin
			eff_seats = SEAT_W'(MAX_SEATS);
		end else begin
			eff_seats = num_seats_q;
		end
	end

	// ---------------- intake ----------------
	// Seat range check happens here so the executor only sees
	// request, release or reject.
	drga_front u_front (
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.cmd       (s_tdata[0]),
		.seat      (s_tdata[5:1]),
		.eff_seats (eff_seats),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_item    (push_item)
	);

	// decouples intake from a long release scan
	drga_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.pop_item  (pop_item)
	);

	// ---------------- execution ----------------
	// Owns lock map and wait queue. Release scan walks the queue oldest
	// first, compacting non-granted waiters in place. The release result
	// is held until the next grant or scan end so its last flag is known.
	drga_back #(
		.MAX_SEATS (MAX_SEATS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.clear      (cfg_wr),
		.eff_seats  (eff_seats),
		.q_valid    (q_valid),
		.q_item     (pop_item),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_ready  (m_tready),
		.out_res    (out_res),
		.lock_free  (lock_free),
		.wait_count (wait_count)
	);

	assign m_tvalid = out_valid;
	assign m_tdata  = {1'b0, out_res.seat, out_res.ev};
	assign m_tlast  = out_res.last;

	// ---------------- checks ----------------
	assign grant_out     = out_valid && (out_res.ev == EV_GRANT);
	assign grant_seat_ok = (out_res.seat != '0) && (out_res.seat <= eff_seats);

	`DRGA_ASSERT(a_cfg_clears, clk, arst_n, cfg_wr |=> (lock_free == '1 && wait_count == '0))
	`DRGA_NEVER(a_wait_bound, clk, arst_n, int'(wait_count) > MAX_SEATS)
	`DRGA_ASSERT(a_grant_seat_ok, clk, arst_n, grant_out |-> grant_seat_ok)

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the dual resource grant arbiter. Commands (request
// or release of a seat's two locks) stream in from a backlog; a local model of
// the lock map and FIFO wait queue predicts every result, and the monitor
// compares each result request field by field. Runs directed corner cases,
// then random traffic over several seat counts and idling/stall phases.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import drga_pkg::*;

	localparam int MAX_SEATS = MAX_SEATS_DEF;
	// cycles without any handshake before the run is declared hung
	localparam int HANG_LIMIT = 2000;
	// settle time after the last result
	localparam int SETTLE_CYCLES = 2 * MAX_SEATS + 8;
	localparam logic [APB_ADDR_W-1:0] NUM_SEATS_ADDR = APB_ADDR_W'(4 * int'(REG_NUM_SEATS));
	localparam int RANDOM_PER_PHASE = 80;

	typedef struct packed {
		logic              op;
		logic [SEAT_W-1:0] seat;
	} seat_cmd_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [7:0]            s_tdata = '0;   // [0] cmd, [5:1] seat, [7:6] zero
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [7:0]            m_tdata;        // [1:0] event_res, [6:2] target_seat, [7] zero
	logic                  m_tlast;

	// stimulus backlog and expected results
	seat_cmd_t cmd_backlog[$];
	result_t   due_events[$];

	// idling knobs, percent of cycles
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	int err_cnt = 0;
	int hang_cnt = 0;

	// shadow of the arbiter state
	logic [CFG_W-1:0]     cfg_seats = NUM_SEATS_RESET;
	logic [MAX_SEATS-1:0] lock_free = '1;
	logic [SEAT_W-1:0]    waiters[$];

	dual_resource_grant_arbiter #(
		.MAX_SEATS(MAX_SEATS)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	task automatic log_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		err_cnt++;
	endtask

	// register value clamped to 2..MAX_SEATS
	function automatic int active_seats();
		int n;
		n = int'(cfg_seats);
		if (n < 2) n = 2;
		if (n > MAX_SEATS) n = MAX_SEATS;
		return n;
	endfunction

	// seat s uses locks s-1 and s, the last seat wraps to lock 0
	function automatic logic [MAX_SEATS-1:0] seat_locks(input logic [SEAT_W-1:0] s, input int n);
		logic [MAX_SEATS-1:0] m;
		int left;
		int right;
		left = int'(s) - 1;
		right = (int'(s) == n) ? 0 : int'(s);
		m = '0;
		m[left] = 1'b1;
		m[right] = 1'b1;
		return m;
	endfunction

	function automatic result_t make_res(input event_t ev, input logic [SEAT_W-1:0] s);
		result_t r;
		r.ev = ev;
		r.seat = s;
		r.last = 1'b0;
		return r;
	endfunction

	// Predicts the results of one accepted command and updates the shadow state.
	function automatic void arbitrate(input logic op, input logic [SEAT_W-1:0] seat);
		int n;
		int grants;
		logic [MAX_SEATS-1:0] m;
		result_t evs[$];
		logic [SEAT_W-1:0] kept[$];
		n = active_seats();
		if (seat == '0 || int'(seat) > n) begin
			evs.insert(evs.size(), make_res(EV_REJECT, seat));
		end else if (op == CMD_REQUEST) begin
			m = seat_locks(seat, n);
			if ((lock_free & m) == m) begin
				lock_free &= ~m;
				evs.insert(evs.size(), make_res(EV_GRANT, seat));
			end else if (waiters.size() < MAX_SEATS) begin
				waiters.insert(waiters.size(), seat);
				evs.insert(evs.size(), make_res(EV_QUEUED, seat));
			end else begin
				// queue full
				evs.insert(evs.size(), make_res(EV_REJECT, seat));
			end
		end else begin
			// locks are freed whoever held them
			lock_free |= seat_locks(seat, n);
			evs.insert(evs.size(), make_res(EV_RELEASE, seat));
			// oldest first, at most two grants, survivors keep their order
			grants = 0;
			foreach (waiters[i]) begin
				m = seat_locks(waiters[i], n);
				if (grants < 2 && waiters[i] != '0 && int'(waiters[i]) <= n
						&& (lock_free & m) == m) begin
					lock_free &= ~m;
					evs.insert(evs.size(), make_res(EV_GRANT, waiters[i]));
					grants++;
				end else begin
					kept.insert(kept.size(), waiters[i]);
				end
			end
			waiters = kept;
		end
		evs[evs.size()-1].last = 1'b1;
		foreach (evs[i]) due_events.insert(due_events.size(), evs[i]);
	endfunction

	task automatic queue_cmd(input logic op, input int seat);
		seat_cmd_t c;
		c.op = op;
		c.seat = SEAT_W'(seat);
		cmd_backlog.insert(cmd_backlog.size(), c);
	endtask

	// mostly valid seats, a few out of range; 55% requests
	function automatic seat_cmd_t random_cmd();
		seat_cmd_t c;
		int n;
		n = active_seats();
		c.op = ($urandom_range(99) < 55) ? CMD_REQUEST : CMD_RELEASE;
		if ($urandom_range(99) < 8) begin
			if (n == MAX_SEATS || $urandom_range(1) == 0)
				c.seat = '0;
			else
				c.seat = SEAT_W'($urandom_range(MAX_SEATS, n + 1));
		end else begin
			c.seat = SEAT_W'($urandom_range(n, 1));
		end
		return c;
	endfunction

	// one APB transfer: setup, then access until pready
	task automatic apb_xfer(input logic wr, input logic [APB_ADDR_W-1:0] addr,
			input logic [APB_DATA_W-1:0] wdata, output logic [APB_DATA_W-1:0] rdata);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// write clears locks and queue; read back the value
	task automatic set_num_seats(input int val);
		logic [APB_DATA_W-1:0] rd;
		apb_xfer(1'b1, NUM_SEATS_ADDR, APB_DATA_W'(val), rd);
		cfg_seats = CFG_W'(val);
		lock_free = '1;
		waiters.delete();
		apb_xfer(1'b0, NUM_SEATS_ADDR, '0, rd);
		if (rd !== APB_DATA_W'(cfg_seats))
			log_mismatch($sformatf("num_seats read %0h, wrote %0h", rd, cfg_seats));
	endtask

	// sender holds off until every command is in and every result is out
	task automatic drain();
		while (cmd_backlog.size() != 0 || s_tvalid) @(posedge clk);
		while (due_events.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic random_phase(input int seats, input int idle, input int stall);
		set_num_seats(seats);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		repeat (RANDOM_PER_PHASE) cmd_backlog.insert(cmd_backlog.size(), random_cmd());
		drain();
	endtask

	// command driver: new request only when the slot is empty or just taken
	always @(posedge clk) begin : drv
		seat_cmd_t c;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				arbitrate(s_tdata[0], s_tdata[5:1]);
			if (!s_tvalid || s_tready) begin
				if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					c = cmd_backlog.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {2'b00, c.seat, c.op};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor with random backpressure
	always @(posedge clk) begin : mon
		result_t want;
		if (arst_n) begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
			if (m_tvalid && m_tready) begin
				if (due_events.size() == 0) begin
					log_mismatch($sformatf("unexpected result ev %0d seat %0d last %0b",
						m_tdata[1:0], m_tdata[6:2], m_tlast));
				end else begin
					want = due_events.pop_front();
					if (m_tdata[1:0] !== want.ev)
						log_mismatch($sformatf("event_res %0d, expected %0d (seat %0d)",
							m_tdata[1:0], want.ev, want.seat));
					if (m_tdata[6:2] !== want.seat)
						log_mismatch($sformatf("target_seat %0d, expected %0d",
							m_tdata[6:2], want.seat));
					if (m_tlast !== want.last)
						log_mismatch($sformatf("last %0b, expected %0b (seat %0d)",
							m_tlast, want.last, want.seat));
				end
			end
		end
	end

	// hang detector: any handshake or bus access resets it
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
			hang_cnt <= 0;
		else
			hang_cnt <= hang_cnt + 1;
		if (hang_cnt >= HANG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// reset seat count of 5: out-of-range seats for both commands
		queue_cmd(CMD_REQUEST, 0);
		queue_cmd(CMD_RELEASE, 6);
		queue_cmd(CMD_REQUEST, 16);
		// seat 2 holds locks 1,2; seats 1 and 3 wait on them
		queue_cmd(CMD_REQUEST, 2);
		queue_cmd(CMD_REQUEST, 1);
		queue_cmd(CMD_REQUEST, 3);
		// release grants both waiters
		queue_cmd(CMD_RELEASE, 2);
		// release by a seat holding nothing still frees its locks
		queue_cmd(CMD_RELEASE, 5);
		// repeated request by a seat already granted
		queue_cmd(CMD_REQUEST, 1);
		drain();

		// register below range clamps to two seats
		set_num_seats(0);
		queue_cmd(CMD_REQUEST, 3);
		queue_cmd(CMD_REQUEST, 1);
		// fill the wait queue, the next request is turned away
		repeat (MAX_SEATS) queue_cmd(CMD_REQUEST, 2);
		queue_cmd(CMD_REQUEST, 2);
		queue_cmd(CMD_RELEASE, 1);
		drain();

		random_phase(MAX_SEATS, 0, 0);
		random_phase(2, 76, 0);
		random_phase(31, 0, 76);
		random_phase($urandom_range(31), 35, 35);

		if (err_cnt == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
